[hw/rtl/motor_reply_frame_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Motor reply frame decoder assertion macros
// Shared assertion forms for the checker of the frame decoder.
// ----------------------------------------------------------------------------
`ifndef MOTOR_REPLY_FRAME_DECODER_UNIT_DEFINES_SVH
`define MOTOR_REPLY_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define MRFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent starts on the following clock edge.
`define MRFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mrfd_pkg.sv]
// ----------------------------------------------------------------------------
// Motor reply frame decoder package
// Types, constants and division helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
package mrfd_pkg;

  localparam int FRAME_W    = 64;
  localparam int LEN_W      = 4;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int VALUE_W    = 24;
  localparam int QUOT_W     = 20;
  localparam int POS_CODE_W = 16;
  localparam int ROT_CODE_W = 12;
  localparam int POS_PROD_W = LIMIT_W + POS_CODE_W;
  localparam int ROT_PROD_W = LIMIT_W + ROT_CODE_W;

  localparam logic [LEN_W-1:0] FULL_FRAME_LEN = 4'd8;
  localparam logic [7:0] REG_REPLY_READ  = 8'h33;
  localparam logic [7:0] REG_REPLY_WRITE = 8'h55;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT   = 8'd2;

  localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 16'd3200;
  localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RST = 16'd7680;
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST   = 16'd2560;

  // Integer-typed register number ranges.
  localparam logic [7:0] INT_REG_A_LO = 8'd7;
  localparam logic [7:0] INT_REG_A_HI = 8'd10;
  localparam logic [7:0] INT_REG_B_LO = 8'd13;
  localparam logic [7:0] INT_REG_B_HI = 8'd16;
  localparam logic [7:0] INT_REG_C_LO = 8'd35;
  localparam logic [7:0] INT_REG_C_HI = 8'd36;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_STATE    = 2'd1,
    KIND_UNKNOWN  = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] position;
    logic [LIMIT_W-1:0] velocity;
    logic [LIMIT_W-1:0] torque;
  } limits_t;

  typedef struct packed {
    logic                  valid;
    frame_kind_t           kind;
    logic [3:0]            fault;
    logic                  pos_neg;
    logic                  vel_neg;
    logic                  tor_neg;
    logic [POS_PROD_W-1:0] pos_prod;
    logic [ROT_PROD_W-1:0] vel_prod;
    logic [ROT_PROD_W-1:0] tor_prod;
    logic [7:0]            drv_temp;
    logic [7:0]            rot_temp;
    logic [7:0]            reg_num;
    logic [31:0]           reg_val;
    logic                  is_int;
  } stage_t;

  typedef struct packed {
    logic                valid;
    frame_kind_t         kind;
    logic [3:0]          fault;
    logic [VALUE_W-1:0]  position;
    logic [VALUE_W-1:0]  velocity;
    logic [VALUE_W-1:0]  torque;
    logic [7:0]          drv_temp;
    logic [7:0]          rot_temp;
    logic [7:0]          reg_num;
    logic [31:0]         reg_val;
    logic                is_int;
  } result_t;

  // floor(16 * a / 65535). Each fold uses 2^16 = 65535 + 1, and the final
  // remainder is below twice the divisor, so one compare finishes it.
  function automatic logic [QUOT_W-1:0] div_pos(input logic [POS_PROD_W-1:0] a);
    logic [35:0] y;
    logic [19:0] q1;
    logic [20:0] r1;
    logic [4:0]  q2;
    logic [16:0] r2;
    logic        fix;
    y   = {a, 4'b0000};
    q1  = y[35:16];
    r1  = {5'b0, y[15:0]} + {1'b0, q1};
    q2  = r1[20:16];
    r2  = {1'b0, r1[15:0]} + {12'b0, q2};
    fix = (r2 >= 17'd65535);
    return q1 + {15'b0, q2} + {19'b0, fix};
  endfunction

  // floor(16 * a / 4095), same folding with 2^12 = 4095 + 1.
  function automatic logic [QUOT_W-1:0] div_rot(input logic [ROT_PROD_W-1:0] a);
    logic [31:0] y;
    logic [19:0] q1;
    logic [20:0] r1;
    logic [8:0]  q2;
    logic [12:0] r2;
    logic        fix;
    y   = {a, 4'b0000};
    q1  = y[31:12];
    r1  = {9'b0, y[11:0]} + {1'b0, q1};
    q2  = r1[20:12];
    r2  = {1'b0, r1[11:0]} + {4'b0, q2};
    fix = (r2 >= 13'd4095);
    return q1 + {11'b0, q2} + {19'b0, fix};
  endfunction

endpackage

[hw/rtl/mrfd_decode.sv]
// ----------------------------------------------------------------------------
// Motor reply frame decoder: classify and multiply stage
// Classifies the frame, extracts fields, and forms limit times code magnitude.
// ----------------------------------------------------------------------------
module mrfd_decode import mrfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [FRAME_W-1:0] frame_bytes,
  input  logic [LEN_W-1:0]   frame_length,
  input  limits_t            limits,
  output stage_t             stage_r
);

  stage_t stage_nxt;

  logic [7:0]            b [8];
  logic [POS_CODE_W-1:0] pos_code;
  logic [ROT_CODE_W-1:0] vel_code;
  logic [ROT_CODE_W-1:0] tor_code;
  logic [POS_CODE_W:0]   pos_twice;
  logic [ROT_CODE_W:0]   vel_twice;
  logic [ROT_CODE_W:0]   tor_twice;
  logic [POS_CODE_W:0]   pos_diff;
  logic [ROT_CODE_W:0]   vel_diff;
  logic [ROT_CODE_W:0]   tor_diff;
  logic                  is_reg;
  logic                  is_state;

  localparam logic [POS_CODE_W:0] POS_M = {1'b0, {POS_CODE_W{1'b1}}};
  localparam logic [ROT_CODE_W:0] ROT_M = {1'b0, {ROT_CODE_W{1'b1}}};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = frame_bytes[8*i +: 8];
    end
  end

  assign pos_code  = {b[1], b[2]};
  assign vel_code  = {b[3], b[4][7:4]};
  assign tor_code  = {b[4][3:0], b[5]};
  assign pos_twice = {pos_code, 1'b0};
  assign vel_twice = {vel_code, 1'b0};
  assign tor_twice = {tor_code, 1'b0};

  // The code sits below the midpoint exactly when its top bit is clear.
  assign pos_diff = pos_code[POS_CODE_W-1] ? (pos_twice - POS_M) : (POS_M - pos_twice);
  assign vel_diff = vel_code[ROT_CODE_W-1] ? (vel_twice - ROT_M) : (ROT_M - vel_twice);
  assign tor_diff = tor_code[ROT_CODE_W-1] ? (tor_twice - ROT_M) : (ROT_M - tor_twice);

  assign is_reg   = (frame_length >= FULL_FRAME_LEN) &&
                    ((b[2] == REG_REPLY_READ) || (b[2] == REG_REPLY_WRITE));
  assign is_state = (frame_length >= FULL_FRAME_LEN) && !is_reg;

  always_comb begin
    stage_nxt       = '0;
    stage_nxt.valid = accept;
    if (frame_length < FULL_FRAME_LEN) begin
      stage_nxt.kind = KIND_UNKNOWN;
    end else if (is_reg) begin
      stage_nxt.kind = KIND_REGISTER;
    end else begin
      stage_nxt.kind = KIND_STATE;
    end

    if (is_reg) begin
      stage_nxt.reg_num = b[3];
      stage_nxt.reg_val = {b[7], b[6], b[5], b[4]};
      stage_nxt.is_int  = ((b[3] >= INT_REG_A_LO) && (b[3] <= INT_REG_A_HI)) ||
                          ((b[3] >= INT_REG_B_LO) && (b[3] <= INT_REG_B_HI)) ||
                          ((b[3] >= INT_REG_C_LO) && (b[3] <= INT_REG_C_HI));
    end

    if (is_state) begin
      stage_nxt.fault    = b[0][3:0];
      stage_nxt.drv_temp = b[6];
      stage_nxt.rot_temp = b[7];
      stage_nxt.pos_neg  = !pos_code[POS_CODE_W-1];
      stage_nxt.vel_neg  = !vel_code[ROT_CODE_W-1];
      stage_nxt.tor_neg  = !tor_code[ROT_CODE_W-1];
      stage_nxt.pos_prod = POS_PROD_W'(limits.position) *
                           POS_PROD_W'(pos_diff[POS_CODE_W-1:0]);
      stage_nxt.vel_prod = ROT_PROD_W'(limits.velocity) *
                           ROT_PROD_W'(vel_diff[ROT_CODE_W-1:0]);
      stage_nxt.tor_prod = ROT_PROD_W'(limits.torque) *
                           ROT_PROD_W'(tor_diff[ROT_CODE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

endmodule

[hw/rtl/mrfd_scale.sv]
// ----------------------------------------------------------------------------
// Motor reply frame decoder: scale stage
// Divides the products by the code span, applies the sign, registers result.
// ----------------------------------------------------------------------------
module mrfd_scale import mrfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  stage_t  stage,
  output result_t result_r
);

  result_t           result_nxt;
  logic [QUOT_W-1:0] pos_q;
  logic [QUOT_W-1:0] vel_q;
  logic [QUOT_W-1:0] tor_q;
  logic [VALUE_W-1:0] pos_mag;
  logic [VALUE_W-1:0] vel_mag;
  logic [VALUE_W-1:0] tor_mag;

  assign pos_q   = div_pos(stage.pos_prod);
  assign vel_q   = div_rot(stage.vel_prod);
  assign tor_q   = div_rot(stage.tor_prod);
  assign pos_mag = VALUE_W'(pos_q);
  assign vel_mag = VALUE_W'(vel_q);
  assign tor_mag = VALUE_W'(tor_q);

  always_comb begin
    result_nxt          = '0;
    result_nxt.valid    = stage.valid;
    result_nxt.kind     = stage.kind;
    result_nxt.fault    = stage.fault;
    result_nxt.position = stage.pos_neg ? (VALUE_W'(0) - pos_mag) : pos_mag;
    result_nxt.velocity = stage.vel_neg ? (VALUE_W'(0) - vel_mag) : vel_mag;
    result_nxt.torque   = stage.tor_neg ? (VALUE_W'(0) - tor_mag) : tor_mag;
    result_nxt.drv_temp = stage.drv_temp;
    result_nxt.rot_temp = stage.rot_temp;
    result_nxt.reg_num  = stage.reg_num;
    result_nxt.reg_val  = stage.reg_val;
    result_nxt.is_int   = stage.is_int;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_r <= '0;
    end else begin
      result_r <= result_nxt;
    end
  end

endmodule

[hw/rtl/motor_reply_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Motor reply frame decoder unit
// A request taken at a clock edge is registered first in the product stage
// and then in the result stage, which drives the out_ ports and strobes
// out_valid for one cycle. Throughput: one request per cycle; busy stays
// low, the receiver cannot stall, and the two pipeline registers (product,
// result) lie between each request and its result.
// Reset clears both stage registers and restores the three limit registers.
// ----------------------------------------------------------------------------
module motor_reply_frame_decoder_unit import mrfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [FRAME_W-1:0]       in_frame_bytes,
  input  logic [LEN_W-1:0]         in_frame_length,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LIMIT_W-1:0]       cfg_data,
  output logic                     out_valid,
  output logic [1:0]               out_frame_kind,
  output logic [3:0]               out_fault_status,
  output logic signed [VALUE_W-1:0] out_position,
  output logic signed [VALUE_W-1:0] out_velocity,
  output logic signed [VALUE_W-1:0] out_torque,
  output logic [7:0]               out_driver_temperature,
  output logic [7:0]               out_rotor_temperature,
  output logic [7:0]               out_register_number,
  output logic [31:0]              out_register_value,
  output logic                     out_value_is_integer
);

  limits_t limits_r;
  limits_t limits_nxt;
  stage_t  stage;
  result_t result;
  logic    accept;
  logic    cfg_write;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_write) begin
      case (cfg_index)
        CFG_POSITION_LIMIT: limits_nxt.position = cfg_data;
        CFG_VELOCITY_LIMIT: limits_nxt.velocity = cfg_data;
        CFG_TORQUE_LIMIT:   limits_nxt.torque   = cfg_data;
        default:            limits_nxt          = limits_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.position <= POSITION_LIMIT_RST;
      limits_r.velocity <= VELOCITY_LIMIT_RST;
      limits_r.torque   <= TORQUE_LIMIT_RST;
    end else begin
      limits_r <= limits_nxt;
    end
  end

  mrfd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .frame_bytes  (in_frame_bytes),
    .frame_length (in_frame_length),
    .limits       (limits_r),
    .stage_r      (stage)
  );

  mrfd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .result_r (result)
  );

  assign out_valid              = result.valid;
  assign out_frame_kind         = result.kind;
  assign out_fault_status       = result.fault;
  assign out_position           = result.position;
  assign out_velocity           = result.velocity;
  assign out_torque             = result.torque;
  assign out_driver_temperature = result.drv_temp;
  assign out_rotor_temperature  = result.rot_temp;
  assign out_register_number    = result.reg_num;
  assign out_register_value     = result.reg_val;
  assign out_value_is_integer   = result.is_int;

endmodule

[hw/rtl/mrfd_checker.sv]
// ----------------------------------------------------------------------------
// Motor reply frame decoder checker
// Port-level checks on request timing and on field zeroing per frame kind.
// ----------------------------------------------------------------------------
`include "motor_reply_frame_decoder_unit_defines.svh"

module mrfd_checker import mrfd_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [1:0]                out_frame_kind,
  input logic [3:0]                out_fault_status,
  input logic signed [VALUE_W-1:0] out_position,
  input logic signed [VALUE_W-1:0] out_velocity,
  input logic signed [VALUE_W-1:0] out_torque,
  input logic [7:0]                out_register_number,
  input logic [31:0]               out_register_value,
  input logic                      out_value_is_integer
);

  // Every request yields exactly one result.
  `MRFD_ASSERT_NEXT(a_req_gives_result, start && !busy, ##1 out_valid, "request lost")

  `MRFD_ASSERT_NOW(a_result_has_req, out_valid, $past(start && !busy, 2),
    "result without request")

  `MRFD_ASSERT_NOW(a_unknown_zero, out_valid && (out_frame_kind == KIND_UNKNOWN),
    (out_fault_status == 4'd0) && (out_position == 0) && (out_register_value == 32'd0)
    && (out_register_number == 8'd0), "unrecognized frame carries data")

  `MRFD_ASSERT_NOW(a_register_no_motion, out_valid && (out_frame_kind == KIND_REGISTER),
    (out_position == 0) && (out_velocity == 0) && (out_torque == 0),
    "register reply carries motion values")

  `MRFD_ASSERT_NOW(a_int_only_register, out_valid && out_value_is_integer,
    out_frame_kind == KIND_REGISTER, "integer flag outside register reply")

endmodule

bind motor_reply_frame_decoder_unit mrfd_checker u_mrfd_checker (.*);

[test/motor_reply_frame_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reply frame decoder testbench
// Drives a directed table of frames, then bursts of random frames across
// several limit settings. Every reply is checked field by field against
// the table or a local decoder model, in order, one per accepted request.
// ----------------------------------------------------------------------------
module motor_reply_frame_decoder_unit_test import mrfd_pkg::*; ();

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          DRAIN_CYCLES    = 4;
  localparam int          NUM_PHASES      = 8;
  localparam int          FRAMES_PER_PHASE = 130;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [15:0] LIMIT_MAX       = 16'hFFFF;

  typedef struct packed {
    frame_kind_t        kind;
    logic [3:0]         fault;
    logic [VALUE_W-1:0] position;
    logic [VALUE_W-1:0] velocity;
    logic [VALUE_W-1:0] torque;
    logic [7:0]         driver_temp;
    logic [7:0]         rotor_temp;
    logic [7:0]         reg_number;
    logic [31:0]        reg_value;
    logic               value_is_int;
  } decoded_reply_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [LEN_W-1:0]   len;
    bit                 typed;
    decoded_reply_t     want;
  } frame_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FRAME_W-1:0]       in_frame_bytes = '0;
  logic [LEN_W-1:0]         in_frame_length = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [LIMIT_W-1:0]       cfg_data = '0;
  logic                     out_valid;
  logic [1:0]               out_frame_kind;
  logic [3:0]               out_fault_status;
  logic signed [VALUE_W-1:0] out_position;
  logic signed [VALUE_W-1:0] out_velocity;
  logic signed [VALUE_W-1:0] out_torque;
  logic [7:0]               out_driver_temperature;
  logic [7:0]               out_rotor_temperature;
  logic [7:0]               out_register_number;
  logic [31:0]              out_register_value;
  logic                     out_value_is_integer;

  // Limits as the decoder should hold them.
  logic [LIMIT_W-1:0] pos_limit = POSITION_LIMIT_RST;
  logic [LIMIT_W-1:0] vel_limit = VELOCITY_LIMIT_RST;
  logic [LIMIT_W-1:0] tor_limit = TORQUE_LIMIT_RST;

  decoded_reply_t pending_replies[$];
  decoded_reply_t head_reply;
  frame_row_t     directed_rows[$];

  int mismatch_count = 0;
  int replies_seen   = 0;
  int register_seen  = 0;
  int state_seen     = 0;
  int unknown_seen   = 0;
  int settings_used  = 1;
  int burst_left     = 0;

  motor_reply_frame_decoder_unit u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_frame_bytes         (in_frame_bytes),
    .in_frame_length        (in_frame_length),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_frame_kind         (out_frame_kind),
    .out_fault_status       (out_fault_status),
    .out_position           (out_position),
    .out_velocity           (out_velocity),
    .out_torque             (out_torque),
    .out_driver_temperature (out_driver_temperature),
    .out_rotor_temperature  (out_rotor_temperature),
    .out_register_number    (out_register_number),
    .out_register_value     (out_register_value),
    .out_value_is_integer   (out_value_is_integer)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Maps a code onto [-limit, +limit] with 4 fractional bits, truncated
  // toward zero.
  function automatic logic [VALUE_W-1:0] scale_code(input logic [15:0] code, input int bits,
                                                    input logic [LIMIT_W-1:0] limit);
    longint full_scale;
    longint offset;
    longint magnitude;
    longint code_l;
    longint limit_l;
    longint scaled;
    code_l     = longint'(code);
    limit_l    = longint'(limit);
    full_scale = (longint'(1) << bits) - 1;
    offset     = 2 * code_l - full_scale;
    magnitude  = (offset < 0) ? -offset : offset;
    scaled     = (limit_l * 16 * magnitude) / full_scale;
    if (offset < 0) begin
      scaled = -scaled;
    end
    return scaled[VALUE_W-1:0];
  endfunction

  function automatic logic is_integer_register(input logic [7:0] num);
    return (num >= INT_REG_A_LO && num <= INT_REG_A_HI) ||
           (num >= INT_REG_B_LO && num <= INT_REG_B_HI) ||
           (num >= INT_REG_C_LO && num <= INT_REG_C_HI);
  endfunction

  function automatic decoded_reply_t decode_frame(input logic [FRAME_W-1:0] f,
                                                  input logic [LEN_W-1:0] len);
    decoded_reply_t r;
    r = '0;
    if (len < FULL_FRAME_LEN) begin
      r.kind = KIND_UNKNOWN;
    end else if (f[23:16] == REG_REPLY_READ || f[23:16] == REG_REPLY_WRITE) begin
      r.kind         = KIND_REGISTER;
      r.reg_number   = f[31:24];
      r.reg_value    = f[63:32];
      r.value_is_int = is_integer_register(f[31:24]);
    end else begin
      r.kind        = KIND_STATE;
      r.fault       = f[3:0];
      r.position    = scale_code({f[15:8], f[23:16]}, POS_CODE_W, pos_limit);
      r.velocity    = scale_code({4'b0, f[31:24], f[39:36]}, ROT_CODE_W, vel_limit);
      r.torque      = scale_code({4'b0, f[35:32], f[47:40]}, ROT_CODE_W, tor_limit);
      r.driver_temp = f[55:48];
      r.rotor_temp  = f[63:56];
    end
    return r;
  endfunction

  function automatic decoded_reply_t unknown_reply();
    decoded_reply_t r;
    r      = '0;
    r.kind = KIND_UNKNOWN;
    return r;
  endfunction

  function automatic decoded_reply_t register_reply(input logic [7:0] num,
                                                    input logic [31:0] value,
                                                    input logic is_int);
    decoded_reply_t r;
    r              = '0;
    r.kind         = KIND_REGISTER;
    r.reg_number   = num;
    r.reg_value    = value;
    r.value_is_int = is_int;
    return r;
  endfunction

  function automatic decoded_reply_t state_reply(input logic [3:0] fault, input int pos,
                                                 input int vel, input int tor,
                                                 input logic [7:0] drv, input logic [7:0] rot);
    decoded_reply_t r;
    r             = '0;
    r.kind        = KIND_STATE;
    r.fault       = fault;
    r.position    = pos[VALUE_W-1:0];
    r.velocity    = vel[VALUE_W-1:0];
    r.torque      = tor[VALUE_W-1:0];
    r.driver_temp = drv;
    r.rotor_temp  = rot;
    return r;
  endfunction

  task automatic add_row(input logic [FRAME_W-1:0] f, input logic [LEN_W-1:0] len,
                         input bit typed, input decoded_reply_t want);
    frame_row_t row;
    row.frame = f;
    row.len   = len;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Directed frames. Full-scale codes map to sixteen times the limit.
  initial begin
    add_row('1, 4'd0, 1'b1, unknown_reply());
    add_row({32'hDEADBEEF, 8'd9, REG_REPLY_READ, 16'h1234}, 4'd7, 1'b1, unknown_reply());
    add_row('0, 4'd8, 1'b1, state_reply(4'h0, -51200, -122880, -40960, 8'h00, 8'h00));
    add_row('1, 4'd8, 1'b1, state_reply(4'hF, 51200, 122880, 40960, 8'hFF, 8'hFF));
    add_row('1, 4'd15, 1'b1, state_reply(4'hF, 51200, 122880, 40960, 8'hFF, 8'hFF));
    add_row({32'hFFFFFFFF, 8'd6, REG_REPLY_READ, 16'h0000}, 4'd8, 1'b1,
            register_reply(8'd6, 32'hFFFFFFFF, 1'b0));
    add_row({32'h12345678, 8'd7, REG_REPLY_WRITE, 16'hABCD}, 4'd8, 1'b1,
            register_reply(8'd7, 32'h12345678, 1'b1));
    add_row({32'h00000000, 8'd10, REG_REPLY_READ, 16'hFFFF}, 4'd9, 1'b1,
            register_reply(8'd10, 32'h00000000, 1'b1));
    add_row({32'h80000001, 8'd11, REG_REPLY_WRITE, 16'hFFFF}, 4'd8, 1'b1,
            register_reply(8'd11, 32'h80000001, 1'b0));
    add_row({32'h13579BDF, 8'd13, REG_REPLY_READ, 16'h0000}, 4'd8, 1'b1,
            register_reply(8'd13, 32'h13579BDF, 1'b1));
    add_row({32'h2468ACE0, 8'd16, REG_REPLY_WRITE, 16'h5A5A}, 4'd12, 1'b1,
            register_reply(8'd16, 32'h2468ACE0, 1'b1));
    add_row({32'h7FFFFFFF, 8'd17, REG_REPLY_READ, 16'hA5A5}, 4'd8, 1'b1,
            register_reply(8'd17, 32'h7FFFFFFF, 1'b0));
    add_row({32'h00000001, 8'd34, REG_REPLY_WRITE, 16'h0F0F}, 4'd8, 1'b1,
            register_reply(8'd34, 32'h00000001, 1'b0));
    add_row({32'h3F800000, 8'd35, REG_REPLY_READ, 16'hF0F0}, 4'd8, 1'b1,
            register_reply(8'd35, 32'h3F800000, 1'b1));
    add_row({32'hC0490FDB, 8'd36, REG_REPLY_WRITE, 16'h0000}, 4'd15, 1'b1,
            register_reply(8'd36, 32'hC0490FDB, 1'b1));
    add_row({32'hFFFF0000, 8'd37, REG_REPLY_READ, 16'hFFFF}, 4'd8, 1'b1,
            register_reply(8'd37, 32'hFFFF0000, 1'b0));
    add_row({32'hA5A55A5A, 8'd255, REG_REPLY_WRITE, 16'h8001}, 4'd8, 1'b1,
            register_reply(8'd255, 32'hA5A55A5A, 1'b0));
    // Near misses on the register reply codes decode as state frames.
    add_row(64'h1234_5678_9A34_BC05, 4'd8, 1'b0, '0);
    add_row(64'h0102_0304_0554_7F0A, 4'd8, 1'b0, '0);
    add_row(64'hA5A5_5A5A_C356_0A0F, 4'd10, 1'b0, '0);
    // Codes on both sides of mid-scale.
    add_row(64'hAA55_FF07_8000_8003, 4'd8, 1'b0, '0);
    add_row(64'h0000_00F8_7FFF_7F0C, 4'd8, 1'b0, '0);
  end

  task automatic random_frame(output logic [FRAME_W-1:0] f, output logic [LEN_W-1:0] len);
    int pick;
    pick = $urandom_range(0, 99);
    f    = {$urandom, $urandom};
    len  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : FULL_FRAME_LEN;
    if (pick < 35) begin
      if (f[23:16] == REG_REPLY_READ || f[23:16] == REG_REPLY_WRITE) begin
        f[16] = ~f[16];
      end
    end else if (pick < 65) begin
      f[23:16] = $urandom_range(0, 1) ? REG_REPLY_READ : REG_REPLY_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        f[31:24] = 8'($urandom_range(0, 40));
      end
    end else if (pick < 80) begin
      len = 4'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) begin
        f[23:16] = REG_REPLY_READ;
      end
    end else if (pick < 90) begin
      // Drive each code to an end of its range.
      {f[15:8], f[23:16]}  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      {f[31:24], f[39:36]} = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      {f[35:32], f[47:40]} = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    end else begin
      len = 4'($urandom_range(0, 15));
    end
  endtask

  task automatic send_frame(input logic [FRAME_W-1:0] f, input logic [LEN_W-1:0] len,
                            input decoded_reply_t want);
    int roll;
    int gap;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 9);
      gap  = (roll < 5) ? 0 : (roll < 8) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      if (gap > 0) begin
        start           <= 1'b0;
        in_frame_bytes  <= {$urandom, $urandom};
        in_frame_length <= 4'($urandom_range(0, 15));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    start           <= 1'b1;
    in_frame_bytes  <= f;
    in_frame_length <= len;
    do @(posedge clk); while (busy);
    pending_replies.push_back(want);
    burst_left--;
  endtask

  task automatic wait_until_drained();
    start      <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POSITION_LIMIT: pos_limit = data;
      CFG_VELOCITY_LIMIT: vel_limit = data;
      CFG_TORQUE_LIMIT:   tor_limit = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("Reply %0d: %s expected %h, got %h", replies_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      case (out_frame_kind)
        KIND_REGISTER: register_seen++;
        KIND_STATE:    state_seen++;
        default:       unknown_seen++;
      endcase
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Reply %0d arrived with no request outstanding", replies_seen);
        end
      end else begin
        head_reply = pending_replies.pop_front();
        compare_field("frame_kind", 32'(head_reply.kind), 32'(out_frame_kind));
        compare_field("fault_status", 32'(head_reply.fault), 32'(out_fault_status));
        compare_field("position", 32'(head_reply.position), 32'($unsigned(out_position)));
        compare_field("velocity", 32'(head_reply.velocity), 32'($unsigned(out_velocity)));
        compare_field("torque", 32'(head_reply.torque), 32'($unsigned(out_torque)));
        compare_field("driver_temperature", 32'(head_reply.driver_temp),
                      32'(out_driver_temperature));
        compare_field("rotor_temperature", 32'(head_reply.rotor_temp),
                      32'(out_rotor_temperature));
        compare_field("register_number", 32'(head_reply.reg_number),
                      32'(out_register_number));
        compare_field("register_value", head_reply.reg_value, out_register_value);
        compare_field("value_is_integer", 32'(head_reply.value_is_int),
                      32'(out_value_is_integer));
      end
      replies_seen++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] f;
    logic [LEN_W-1:0]   len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_frame(directed_rows[i].frame, directed_rows[i].len,
                 directed_rows[i].typed ? directed_rows[i].want
                                        : decode_frame(directed_rows[i].frame,
                                                       directed_rows[i].len));
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        // Limits only change once every request in flight has replied.
        wait_until_drained();
        settings_used++;
        case (phase)
          1: begin
            write_limit(CFG_POSITION_LIMIT, LIMIT_MAX);
            write_limit(CFG_VELOCITY_LIMIT, LIMIT_MAX);
            write_limit(CFG_TORQUE_LIMIT, LIMIT_MAX);
          end
          2: begin
            write_limit(CFG_POSITION_LIMIT, '0);
            write_limit(CFG_VELOCITY_LIMIT, '0);
            write_limit(CFG_TORQUE_LIMIT, '0);
          end
          3: begin
            write_limit(CFG_POSITION_LIMIT, 16'd1);
            write_limit(CFG_VELOCITY_LIMIT, 16'd1);
            write_limit(CFG_TORQUE_LIMIT, 16'd1);
          end
          4: begin
            write_limit(CFG_POSITION_LIMIT, LIMIT_MAX);
            write_limit(CFG_VELOCITY_LIMIT, '0);
            write_limit(CFG_TORQUE_LIMIT, 16'($urandom_range(0, 65535)));
            // Writes past the last register must leave the limits alone.
            write_limit(CFG_IDX_W'(CFG_TORQUE_LIMIT + 1), 16'($urandom_range(0, 65535)));
            write_limit('1, 16'($urandom_range(0, 65535)));
          end
          default: begin
            write_limit(CFG_POSITION_LIMIT, 16'($urandom_range(0, 65535)));
            write_limit(CFG_VELOCITY_LIMIT, 16'($urandom_range(0, 65535)));
            write_limit(CFG_TORQUE_LIMIT, 16'($urandom_range(0, 65535)));
          end
        endcase
      end
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        random_frame(f, len);
        send_frame(f, len, decode_frame(f, len));
      end
    end

    wait_until_drained();
    if (pending_replies.size() != 0) begin
      mismatch_count += pending_replies.size();
      $display("%0d replies never arrived", pending_replies.size());
    end

    $display("Checked %0d replies: %0d register, %0d state, %0d unrecognized frames",
             replies_seen, register_seen, state_seen, unknown_seen);
    $display("Limit settings exercised: %0d, including all-zero and all-maximum; %0d mismatches",
             settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mrfd_pkg.sv
hw/rtl/mrfd_decode.sv
hw/rtl/mrfd_scale.sv
hw/rtl/motor_reply_frame_decoder_unit.sv
hw/rtl/mrfd_checker.sv
test/motor_reply_frame_decoder_unit_test.sv
